// File: rtl/core/spg_pkg.sv
// Shared types and constants for the step pulse generator.
`timescale 1ns / 1ps

package spg_pkg;

  // Command codes carried in the op field.
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_START_MOVE = 3'd1,
    OP_START_CONT = 3'd2,
    OP_STOP_CONT  = 3'd3,
    OP_SET_DIR    = 3'd4,
    OP_ENABLE     = 3'd5,
    OP_DISABLE    = 3'd6
  } op_t;

  localparam int unsigned TIME_W  = 20;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SPEED_W = 12;

  localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] RESET_HALF  = TIME_W'(1000);

  // One input transaction.
  typedef struct packed {
    logic [2:0]         op;
    logic [TIME_W-1:0]  elapsed_us;
    logic [COUNT_W-1:0] step_count;
    logic [TIME_W-1:0]  half_period_us;
    logic [SPEED_W-1:0] speed;
    logic               direction;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic               accepted;
    logic               step_level;
    logic               direction_level;
    logic               driver_disabled;
    logic               move_active;
    logic               continuous_active;
    logic [COUNT_W-1:0] steps_left;
    logic [SPEED_W-1:0] speed_readback;
  } result_t;

endpackage

// File: rtl/core/spg_core.sv
// Axis state registers and the single-pass update for one transaction.
`timescale 1ns / 1ps

module spg_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  spg_pkg::item_t   item,
  output spg_pkg::result_t res
);
  import spg_pkg::*;

  logic               move_running, move_running_next;
  logic               move_phase_high, move_phase_high_next;
  logic [COUNT_W-1:0] move_remaining, move_remaining_next;
  logic [TIME_W-1:0]  move_elapsed, move_elapsed_next;
  logic [TIME_W-1:0]  move_half, move_half_next;
  logic               cont_running, cont_running_next;
  logic               cont_phase_high, cont_phase_high_next;
  logic [TIME_W-1:0]  cont_elapsed, cont_elapsed_next;
  logic [TIME_W-1:0]  cont_half, cont_half_next;
  logic [SPEED_W-1:0] cont_speed, cont_speed_next;
  logic               step_pin, step_pin_next;
  logic               dir_pin, dir_pin_next;
  logic               enable_pin, enable_pin_next;
  logic               acc;

  logic [TIME_W:0]    move_sum;
  logic [TIME_W:0]    cont_sum;
  logic [TIME_W-1:0]  move_sat;
  logic [TIME_W-1:0]  cont_sat;
  logic [COUNT_W-1:0] remaining_dec;

  // Saturating time accumulation for both counters.
  assign move_sum = {1'b0, move_elapsed} + {1'b0, item.elapsed_us};
  assign cont_sum = {1'b0, cont_elapsed} + {1'b0, item.elapsed_us};
  assign move_sat = move_sum[TIME_W] ? ELAPSED_MAX : move_sum[TIME_W-1:0];
  assign cont_sat = cont_sum[TIME_W] ? ELAPSED_MAX : cont_sum[TIME_W-1:0];

  // Pulse count after a falling edge; never wraps below zero.
  assign remaining_dec = (move_remaining != '0) ? move_remaining - COUNT_W'(1) : move_remaining;

  // Next-state logic for one transaction.
  always_comb begin
    move_running_next    = move_running;
    move_phase_high_next = move_phase_high;
    move_remaining_next  = move_remaining;
    move_elapsed_next    = move_elapsed;
    move_half_next       = move_half;
    cont_running_next    = cont_running;
    cont_phase_high_next = cont_phase_high;
    cont_elapsed_next    = cont_elapsed;
    cont_half_next       = cont_half;
    cont_speed_next      = cont_speed;
    step_pin_next        = step_pin;
    dir_pin_next         = dir_pin;
    enable_pin_next      = enable_pin;
    acc                  = 1'b0;

    case (op_t'(item.op))
      OP_TICK: begin
        // Continuous time keeps running even while a move has priority.
        if (cont_running) begin
          cont_elapsed_next = cont_sat;
        end
        if (move_running) begin
          if (move_sat < move_half) begin
            move_elapsed_next = move_sat;
          end else begin
            move_elapsed_next = '0;
            if (!move_phase_high) begin
              step_pin_next        = 1'b1;
              move_phase_high_next = 1'b1;
            end else begin
              step_pin_next        = 1'b0;
              move_phase_high_next = 1'b0;
              move_remaining_next  = remaining_dec;
              if (remaining_dec == '0) begin
                move_running_next = 1'b0;
              end
            end
          end
        end else if (cont_running && (cont_half != '0)) begin
          if (cont_sat >= cont_half) begin
            cont_elapsed_next    = '0;
            cont_phase_high_next = !cont_phase_high;
            step_pin_next        = !cont_phase_high;
          end
        end
      end
      OP_START_MOVE: begin
        // A move is refused while anything runs or with a zero count or period.
        if (!cont_running && !move_running && (item.step_count != '0) &&
            (item.half_period_us != '0)) begin
          move_remaining_next  = item.step_count;
          move_phase_high_next = 1'b0;
          move_running_next    = 1'b1;
          move_half_next       = item.half_period_us;
          move_elapsed_next    = '0;
          step_pin_next        = 1'b0;
          acc                  = 1'b1;
        end
      end
      OP_START_CONT: begin
        cont_running_next    = 1'b1;
        cont_speed_next      = item.speed;
        cont_half_next       = item.half_period_us;
        cont_phase_high_next = 1'b0;
        cont_elapsed_next    = '0;
        step_pin_next        = 1'b0;
      end
      OP_STOP_CONT: begin
        cont_running_next    = 1'b0;
        cont_speed_next      = '0;
        cont_half_next       = '0;
        cont_phase_high_next = 1'b0;
        step_pin_next        = 1'b0;
      end
      OP_SET_DIR: begin
        dir_pin_next = item.direction;
      end
      OP_ENABLE: begin
        enable_pin_next = 1'b0;
      end
      OP_DISABLE: begin
        // Disable stops continuous mode but lets a move finish.
        cont_running_next    = 1'b0;
        cont_speed_next      = '0;
        cont_half_next       = '0;
        cont_phase_high_next = 1'b0;
        step_pin_next        = 1'b0;
        enable_pin_next      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result reflects the state after this transaction.
  always_comb begin
    res.accepted          = acc;
    res.step_level        = step_pin_next;
    res.direction_level   = dir_pin_next;
    res.driver_disabled   = enable_pin_next;
    res.move_active       = move_running_next;
    res.continuous_active = cont_running_next;
    res.steps_left        = move_remaining_next;
    res.speed_readback    = cont_speed_next;
  end

  // State registers, updated once per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_running    <= 1'b0;
      move_phase_high <= 1'b0;
      move_remaining  <= '0;
      move_elapsed    <= '0;
      move_half       <= RESET_HALF;
      cont_running    <= 1'b0;
      cont_phase_high <= 1'b0;
      cont_elapsed    <= '0;
      cont_half       <= '0;
      cont_speed      <= '0;
      step_pin        <= 1'b0;
      dir_pin         <= 1'b0;
      enable_pin      <= 1'b1;
    end else if (fire) begin
      move_running    <= move_running_next;
      move_phase_high <= move_phase_high_next;
      move_remaining  <= move_remaining_next;
      move_elapsed    <= move_elapsed_next;
      move_half       <= move_half_next;
      cont_running    <= cont_running_next;
      cont_phase_high <= cont_phase_high_next;
      cont_elapsed    <= cont_elapsed_next;
      cont_half       <= cont_half_next;
      cont_speed      <= cont_speed_next;
      step_pin        <= step_pin_next;
      dir_pin         <= dir_pin_next;
      enable_pin      <= enable_pin_next;
    end
  end

endmodule

// File: rtl/core/stepper_step_pulse_generator.sv
// Top level of the step pulse generator: input register, core and result register.
`timescale 1ns / 1ps

// Step/dir/enable pulse generator for one stepper axis.
// Input channel (in_valid/in_ready) carries one transaction per tick or
// command: op selects tick, start move, start or stop continuous mode,
// set direction, enable or disable. Output channel (out_valid/out_ready)
// returns exactly one result per input transaction, in order, with the
// pin levels and status after that transaction.
// The input register loads at the accepting edge, and the result is valid
// once the result register loads.
// Throughput: one transaction per cycle while the receiver keeps up; the
// axis state is updated in a single pass as the transaction moves from the
// input register into the result register.
// Reset: synchronous, active high. It empties both registers and puts the
// axis into its idle state: step and direction low, driver disabled, no
// move, no continuous run, move half period 1000 us.
// When the receiver stalls, the result register holds its transaction and
// the input register holds the next one; in_ready drops once both are full.
module stepper_step_pulse_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  op,
  input  logic [spg_pkg::TIME_W-1:0]  elapsed_us,
  input  logic [spg_pkg::COUNT_W-1:0] step_count,
  input  logic [spg_pkg::TIME_W-1:0]  half_period_us,
  input  logic [spg_pkg::SPEED_W-1:0] speed,
  input  logic                        direction,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic                        step_level,
  output logic                        direction_level,
  output logic                        driver_disabled,
  output logic                        move_active,
  output logic                        continuous_active,
  output logic [spg_pkg::COUNT_W-1:0] steps_left,
  output logic [spg_pkg::SPEED_W-1:0] speed_readback
);
  import spg_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  logic    out_free;
  result_t core_res;
  result_t out_res;

  // Pipeline flow control.
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.op             <= op;
      s1_item.elapsed_us     <= elapsed_us;
      s1_item.step_count     <= step_count;
      s1_item.half_period_us <= half_period_us;
      s1_item.speed          <= speed;
      s1_item.direction      <= direction;
    end
  end

  // Axis state and update logic.
  spg_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_item),
    .res  (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign accepted          = out_res.accepted;
  assign step_level        = out_res.step_level;
  assign direction_level   = out_res.direction_level;
  assign driver_disabled   = out_res.driver_disabled;
  assign move_active       = out_res.move_active;
  assign continuous_active = out_res.continuous_active;
  assign steps_left        = out_res.steps_left;
  assign speed_readback    = out_res.speed_readback;

  // A move that was accepted is running and nothing else is.
  a_accept_starts_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> move_active && !continuous_active && (steps_left != '0))
    else $error("accepted move is not reported as running");

  // A move runs exactly while pulses remain.
  a_move_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (move_active == (steps_left != '0)))
    else $error("move_active disagrees with steps_left");

  // The stored speed is cleared whenever continuous mode is off.
  a_speed_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && !continuous_active |-> (speed_readback == '0))
    else $error("speed readback nonzero while stopped");

  // With both registers full and the receiver stalled, no new input is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the stepper step pulse generator.
`timescale 1ns / 1ps

module tb_top;
  import spg_pkg::*;

  // Opcode that the block must ignore.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MOTION_ITEMS = 600;
  localparam int REPORT_CAP = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] op = '0;
  logic [TIME_W-1:0] elapsed_us = '0;
  logic [COUNT_W-1:0] step_count = '0;
  logic [TIME_W-1:0] half_period_us = '0;
  logic [SPEED_W-1:0] speed = '0;
  logic direction = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic step_level;
  logic direction_level;
  logic driver_disabled;
  logic move_active;
  logic continuous_active;
  logic [COUNT_W-1:0] steps_left;
  logic [SPEED_W-1:0] speed_readback;

  // Predicted axis state.
  logic mv_run = 1'b0;
  logic mv_high = 1'b0;
  logic [COUNT_W-1:0] mv_left = '0;
  logic [TIME_W-1:0] mv_time = '0;
  logic [TIME_W-1:0] mv_half = RESET_HALF;
  logic ct_run = 1'b0;
  logic ct_high = 1'b0;
  logic [TIME_W-1:0] ct_time = '0;
  logic [TIME_W-1:0] ct_half = '0;
  logic [SPEED_W-1:0] ct_speed = '0;
  logic pin_step = 1'b0;
  logic pin_dir = 1'b0;
  logic pin_disable = 1'b1;

  result_t expected_status[$];
  result_t want;
  int mismatches = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int hold_request = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  stepper_step_pulse_generator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .elapsed_us(elapsed_us),
    .step_count(step_count),
    .half_period_us(half_period_us),
    .speed(speed),
    .direction(direction),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted(accepted),
    .step_level(step_level),
    .direction_level(direction_level),
    .driver_disabled(driver_disabled),
    .move_active(move_active),
    .continuous_active(continuous_active),
    .steps_left(steps_left),
    .speed_readback(speed_readback)
  );

  always #5 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (hold_request > 0) begin
      stall_left = hold_request - 1;
      hold_request = 0;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
  endtask

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("result transaction with no prediction pending");
      end else begin
        want = expected_status.pop_front();
        check_field("accepted", 32'(accepted), 32'(want.accepted));
        check_field("step_level", 32'(step_level), 32'(want.step_level));
        check_field("direction_level", 32'(direction_level), 32'(want.direction_level));
        check_field("driver_disabled", 32'(driver_disabled), 32'(want.driver_disabled));
        check_field("move_active", 32'(move_active), 32'(want.move_active));
        check_field("continuous_active", 32'(continuous_active),
                    32'(want.continuous_active));
        check_field("steps_left", steps_left, want.steps_left);
        check_field("speed_readback", 32'(speed_readback), 32'(want.speed_readback));
      end
    end
  end

  function automatic logic [TIME_W-1:0] add_clamped(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? ELAPSED_MAX : sum[TIME_W-1:0];
  endfunction

  task automatic halt_continuous();
    ct_run = 1'b0;
    ct_speed = '0;
    ct_half = '0;
    ct_high = 1'b0;
    pin_step = 1'b0;
  endtask

  // Update the predicted axis state for one transaction and queue its result.
  task automatic advance_axis_model(input item_t it);
    result_t r;
    logic took;
    took = 1'b0;
    case (it.op)
      OP_TICK: begin
        if (ct_run) ct_time = add_clamped(ct_time, it.elapsed_us);
        if (mv_run) begin
          mv_time = add_clamped(mv_time, it.elapsed_us);
          if (mv_time >= mv_half) begin
            mv_time = '0;
            if (!mv_high) begin
              pin_step = 1'b1;
              mv_high = 1'b1;
            end else begin
              pin_step = 1'b0;
              mv_high = 1'b0;
              if (mv_left != 0) mv_left--;
              if (mv_left == 0) mv_run = 1'b0;
            end
          end
        end else if (ct_run && ct_half != 0 && ct_time >= ct_half) begin
          ct_time = '0;
          ct_high = !ct_high;
          pin_step = ct_high;
        end
      end
      OP_START_MOVE: begin
        if (!ct_run && !mv_run && it.step_count != 0 && it.half_period_us != 0) begin
          mv_left = it.step_count;
          mv_high = 1'b0;
          mv_run = 1'b1;
          mv_half = it.half_period_us;
          mv_time = '0;
          pin_step = 1'b0;
          took = 1'b1;
        end
      end
      OP_START_CONT: begin
        ct_run = 1'b1;
        ct_speed = it.speed;
        ct_half = it.half_period_us;
        ct_high = 1'b0;
        ct_time = '0;
        pin_step = 1'b0;
      end
      OP_STOP_CONT: halt_continuous();
      OP_SET_DIR: pin_dir = it.direction;
      OP_ENABLE: pin_disable = 1'b0;
      OP_DISABLE: begin
        halt_continuous();
        pin_disable = 1'b1;
      end
      default: ;
    endcase
    r.accepted = took;
    r.step_level = pin_step;
    r.direction_level = pin_dir;
    r.driver_disabled = pin_disable;
    r.move_active = mv_run;
    r.continuous_active = ct_run;
    r.steps_left = mv_left;
    r.speed_readback = ct_speed;
    expected_status.push_back(r);
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one input transaction and wait until the block takes it.
  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    elapsed_us <= it.elapsed_us;
    step_count <= it.step_count;
    half_period_us <= it.half_period_us;
    speed <= it.speed;
    direction <= it.direction;
    do @(posedge clk); while (!in_ready);
    advance_axis_model(it);
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_op(input logic [2:0] code, input logic [TIME_W-1:0] dt,
                         input logic [COUNT_W-1:0] cnt, input logic [TIME_W-1:0] half,
                         input logic [SPEED_W-1:0] spd, input logic dir);
    item_t it;
    it.op = code;
    it.elapsed_us = dt;
    it.step_count = cnt;
    it.half_period_us = half;
    it.speed = spd;
    it.direction = dir;
    send_item(it);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_for_results(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Refused starts, a short move, and a largest elapsed-time tick during the move.
  task automatic test_move_commands();
    send_op(OP_TICK, ELAPSED_MAX, '0, '0, '0, 1'b0);
    send_op(OP_START_MOVE, '0, 32'd5, '0, '0, 1'b0);
    send_op(OP_START_MOVE, '0, '0, 20'd7, '0, 1'b0);
    send_op(OP_ENABLE, '0, '0, '0, '0, 1'b0);
    send_op(OP_SET_DIR, '0, '0, '0, '0, 1'b1);
    send_op(OP_START_MOVE, '0, 32'd2, 20'd5, '0, 1'b0);
    send_op(OP_START_MOVE, '0, 32'hFFFF_FFFF, ELAPSED_MAX, '0, 1'b0);
    send_op(OP_TICK, 20'd3, '0, '0, '0, 1'b0);
    send_op(OP_TICK, 20'd2, '0, '0, '0, 1'b0);
    send_op(OP_TICK, ELAPSED_MAX, '0, '0, '0, 1'b0);
  endtask

  // Continuous mode with a refused move start: pin forced low on restart, time
  // kept accumulating with a zero half period, and disable.
  task automatic test_continuous_commands();
    send_op(OP_START_CONT, '0, '0, ELAPSED_MAX, 12'hFFF, 1'b0);
    send_op(OP_TICK, ELAPSED_MAX, '0, '0, '0, 1'b0);
    send_op(OP_STOP_CONT, '0, '0, '0, '0, 1'b0);
    send_op(OP_START_CONT, '0, '0, ELAPSED_MAX, 12'hFFF, 1'b0);
    send_op(OP_TICK, ELAPSED_MAX, '0, '0, '0, 1'b0);
    send_op(OP_TICK, '0, '0, '0, '0, 1'b0);
    send_op(OP_START_MOVE, '0, 32'd3, 20'd2, '0, 1'b0);
    send_op(OP_START_CONT, '0, '0, '0, 12'd1, 1'b0);
    send_op(OP_TICK, ELAPSED_MAX, '0, '0, '0, 1'b0);
    send_op(OP_DISABLE, '0, '0, '0, '0, 1'b0);
  endtask

  // Unused opcode, direction low, and a one-microsecond continuous run.
  task automatic test_misc_commands();
    send_op(OP_UNUSED, ELAPSED_MAX, 32'hFFFF_FFFF, ELAPSED_MAX, 12'hFFF, 1'b1);
    send_op(OP_SET_DIR, '0, '0, '0, '0, 1'b0);
    send_op(OP_START_CONT, '0, '0, 20'd1, '0, 1'b0);
    send_op(OP_TICK, 20'd1, '0, '0, '0, 1'b0);
    send_op(OP_STOP_CONT, '0, '0, '0, '0, 1'b0);
  endtask

  // The receiver holds off for a long stretch while transactions keep coming.
  task automatic test_back_pressure();
    int i;
    idle_on = 1'b0;
    hold_request = 300;
    send_op(OP_ENABLE, '0, '0, '0, '0, 1'b0);
    send_op(OP_START_MOVE, '0, 32'd8, 20'd3, '0, 1'b0);
    for (i = 0; i < 40; i++)
      send_op(OP_TICK, TIME_W'($urandom_range(0, 4)), '0, '0, '0, 1'b0);
    idle_on = 1'b1;
  endtask

  // The sender pauses until the block has returned everything.
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 6; i++)
      send_op(OP_TICK, TIME_W'($urandom_range(0, 6)), '0, '0, '0, 1'b0);
    wait_for_results(4);
    for (i = 0; i < 4; i++) send_op(OP_TICK, ELAPSED_MAX, '0, '0, '0, 1'b0);
  endtask

  // Random moves, continuous runs and noise transactions.
  task automatic test_random_motion();
    int goal, kind, k, i;
    logic [TIME_W-1:0] half;
    logic [2:0] code;
    logic [COUNT_W-1:0] cnt;
    goal = items_sent + MOTION_ITEMS;
    while (items_sent < goal) begin
      idle_on = ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // Finite move with ticks around its half period.
        if (pin_disable || $urandom_range(0, 3) == 0) send_op(OP_ENABLE, '0, '0, '0, '0, 1'b0);
        if ($urandom_range(0, 2) == 0)
          send_op(OP_SET_DIR, '0, '0, '0, '0, 1'($urandom_range(0, 1)));
        if (ct_run && $urandom_range(0, 3) != 0) send_op(OP_STOP_CONT, '0, '0, '0, '0, 1'b0);
        half = TIME_W'($urandom_range(1, 40));
        send_op(OP_START_MOVE, '0, $urandom_range(1, 12), half, '0, 1'b0);
        k = $urandom_range(2, 20);
        for (i = 0; i < k; i++) begin
          case ($urandom_range(0, 19))
            0: send_op(OP_START_CONT, '0, '0, TIME_W'($urandom_range(0, 20)),
                       SPEED_W'($urandom_range(0, 4095)), 1'b0);
            1: send_op(OP_STOP_CONT, '0, '0, '0, '0, 1'b0);
            2: send_op(OP_START_MOVE, '0, $urandom_range(1, 9),
                       TIME_W'($urandom_range(0, 9)), '0, 1'b0);
            default: send_op(OP_TICK, TIME_W'($urandom_range(0, half + half / 2)),
                             '0, '0, '0, 1'b0);
          endcase
        end
        if ($urandom_range(0, 1) == 0) begin
          while (mv_run) send_op(OP_TICK, ELAPSED_MAX, '0, '0, '0, 1'b0);
        end
      end else if (kind < 75) begin
        // Continuous run, ended by stop, by disable, or left running.
        if ($urandom_range(0, 1) == 0) send_op(OP_ENABLE, '0, '0, '0, '0, 1'b0);
        half = ($urandom_range(0, 9) == 0) ? '0 : TIME_W'($urandom_range(1, 30));
        send_op(OP_START_CONT, '0, '0, half, SPEED_W'($urandom_range(0, 4095)), 1'b0);
        k = $urandom_range(2, 16);
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 9) == 0)
            send_op(OP_SET_DIR, '0, '0, '0, '0, 1'($urandom_range(0, 1)));
          else
            send_op(OP_TICK, TIME_W'($urandom_range(0, 2 * half + 1)), '0, '0, '0, 1'b0);
        end
        case ($urandom_range(0, 2))
          0: send_op(OP_STOP_CONT, '0, '0, '0, '0, 1'b0);
          1: send_op(OP_DISABLE, '0, '0, '0, '0, 1'b0);
          default: ;
        endcase
      end else begin
        // Noise: any opcode with any field values.
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) begin
          code = 3'($urandom_range(0, 7));
          cnt = $urandom;
          half = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, ELAPSED_MAX))
                                             : TIME_W'($urandom_range(0, 64));
          // Keep accepted moves short so the axis does not lock up.
          if (code == OP_START_MOVE && !mv_run && !ct_run && half != 0)
            cnt = $urandom_range(1, 16);
          send_op(code,
                  ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, ELAPSED_MAX))
                                              : TIME_W'($urandom_range(0, 64)),
                  cnt, half, SPEED_W'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_move_commands();
    test_continuous_commands();
    test_misc_commands();
    test_back_pressure();
    test_drain_pause();
    test_random_motion();
    wait_for_results(10);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
